// ===== src/hftb_pkg.sv =====
`default_nettype none

package hftb_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_CAPACITY    = 2'd0;
	localparam logic [1:0] REG_REFILL_RATE = 2'd1;
	localparam logic [1:0] REG_HASH_SEED   = 2'd2;

	localparam logic [31:0] SEED_RESET = 32'd2023;

	// murmur3 x86 32 constants
	localparam logic [31:0] MUR_C1  = 32'hcc9e2d51;
	localparam logic [31:0] MUR_C2  = 32'h1b873593;
	localparam logic [31:0] MUR_N   = 32'he6546b64;
	localparam logic [31:0] MUR_LEN = 32'd4;
	localparam logic [31:0] MUR_F1  = 32'h85ebca6b;
	localparam logic [31:0] MUR_F2  = 32'hc2b2ae35;

	function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned r);
		return (v << r) | (v >> (32 - r));
	endfunction

endpackage

`default_nettype wire

// ===== src/hashed_flow_token_bucket.sv =====
`default_nettype none

// channel | direction | handshake          | payload
// in      | sink      | in_valid/in_stall   | flow_key, packet_bytes, arrival_time
// out     | source    | out_valid/out_stall | over_limit
// cfg     | sink      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one packet is worked on at a time, and no new one is accepted before it is done: one shared
// 32x33 multiplier computes the four hash products, the bucket reduction and
// the refill increment in turn, then one read-modify-write of the bucket memory.
// after reset a clearing pass zeroes the bucket memory one bucket at a time, during
// which no packet is accepted; config writes are taken at all times.
// a result waiting under out_stall holds the next result in its last state,
// which delays the packet after it until the stall ends.

module hashed_flow_token_bucket
	import hftb_pkg::*;
#(
	parameter int BUCKETS   = 4096,
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] flow_key,
	input  wire logic [15:0] packet_bytes,
	input  wire logic [31:0] arrival_time,

	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             over_limit,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int TW = 32 + FRAC_BITS;
	localparam int EW = 32 + TW + 32;
	localparam int QSHIFT = 32 + $clog2(BUCKETS);
	localparam logic [32:0] MRECIP = 33'((65'd1 << QSHIFT) / BUCKETS);
	localparam logic [31:0] NBUCK = 32'(BUCKETS);
	localparam logic [AW-1:0] LAST_IDX = AW'(BUCKETS - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_H2, S_H3, S_H4, S_H5, S_MOD1, S_MOD2, S_READ, S_EVAL, S_DEC, S_DONE
	} state_t;

	state_t state_q;

	logic [31:0] capacity_q, refill_rate_q, hash_seed_q;
	logic        clearing_q;
	logic [AW-1:0] clr_idx_q;

	logic [31:0] key_q, time_q;
	logic [15:0] bytes_q;
	logic [31:0] hash_q;
	logic [AW-1:0] pos_q;
	logic [64:0] prod_q;
	logic [TW-1:0] refill_q;
	logic        res_q;
	logic        out_valid_q, over_limit_q;

	logic [EW-1:0] mem [BUCKETS];
	logic [EW-1:0] rd_q;

	logic [31:0] mul_a;
	logic [32:0] mul_b;
	logic [31:0] h3, h5, qv, rq, r32;
	logic [AW-1:0] rd_addr;

	logic [31:0] rd_owner, rd_last, elapsed;
	logic [TW-1:0] rd_level, cap, need, headroom, sum, new_level;
	logic        full, other, keep, fits;
	logic        wr_en;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;

	assign rd_owner = rd_q[EW-1 -: 32];
	assign rd_level = rd_q[TW+31 -: TW];
	assign rd_last  = rd_q[31:0];

	// elapsed ticks wrap modulo 2^32
	assign elapsed = time_q - rd_last;

	assign cap  = TW'(capacity_q) << FRAC_BITS;
	assign need = TW'(bytes_q) << FRAC_BITS;

	// hash finishing steps
	always_comb begin
		logic [31:0] h;
		h  = hash_seed_q ^ prod_q[31:0];
		h  = rotl32(h, 13);
		h  = (h << 2) + h + MUR_N;
		h  = h ^ MUR_LEN;
		h3 = h ^ (h >> 16);
		h5 = prod_q[31:0] ^ (prod_q[31:0] >> 16);
	end

	// bucket index: barrett estimate leaves a remainder below twice BUCKETS
	assign qv      = 32'(prod_q >> QSHIFT);
	assign rq      = hash_q - prod_q[31:0];
	assign r32     = (rq >= NBUCK) ? rq - NBUCK : rq;
	assign rd_addr = AW'(r32);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_IDLE: begin
				mul_a = flow_key;
				mul_b = 33'(MUR_C1);
			end
			S_H2: begin
				mul_a = rotl32(prod_q[31:0], 15);
				mul_b = 33'(MUR_C2);
			end
			S_H3: begin
				mul_a = h3;
				mul_b = 33'(MUR_F1);
			end
			S_H4: begin
				mul_a = prod_q[31:0] ^ (prod_q[31:0] >> 13);
				mul_b = 33'(MUR_F2);
			end
			S_H5: begin
				mul_a = h5;
				mul_b = MRECIP;
			end
			S_MOD1: begin
				mul_a = qv;
				mul_b = 33'(NBUCK);
			end
			S_READ: begin
				mul_a = refill_rate_q;
				mul_b = {1'b0, elapsed};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 65'(mul_a) * 65'(mul_b);
	end

	// refill saturating at capacity
	assign headroom = cap - rd_level;
	assign full     = (rd_level >= cap) || (prod_q[63:0] >= 64'(headroom));
	assign sum      = rd_level + TW'(prod_q[63:0]);

	// another flow owns a bucket that has not refilled to capacity
	assign other     = (rd_owner != '0) && (rd_owner != key_q);
	assign keep      = other && (refill_q < cap);
	assign new_level = (rd_owner != key_q) ? cap : refill_q;
	assign fits      = new_level >= need;

	assign wr_en   = clearing_q || ((state_q == S_DEC) && !keep);
	assign wr_addr = clearing_q ? clr_idx_q : pos_q;
	assign wr_data = clearing_q ? '0 :
		{key_q, (fits ? new_level - need : new_level), time_q};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (state_q == S_MOD2) begin
			rd_q <= mem[rd_addr];
		end
	end

	// per-packet datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			key_q   <= flow_key;
			bytes_q <= packet_bytes;
			time_q  <= arrival_time;
		end
		if (state_q == S_H5) begin
			hash_q <= h5;
		end
		if (state_q == S_MOD2) begin
			pos_q <= rd_addr;
		end
		if (state_q == S_EVAL) begin
			refill_q <= full ? cap : sum;
		end
		if (state_q == S_DEC) begin
			res_q <= !keep && !fits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q    <= '0;
			refill_rate_q <= '0;
			hash_seed_q   <= SEED_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_CAPACITY) begin
				capacity_q <= cfg_data;
			end
			if (cfg_index == REG_REFILL_RATE) begin
				refill_rate_q <= cfg_data;
			end
			if (cfg_index == REG_HASH_SEED) begin
				hash_seed_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			clearing_q   <= 1'b1;
			clr_idx_q    <= '0;
			out_valid_q  <= 1'b0;
			over_limit_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == LAST_IDX) begin
					clearing_q <= 1'b0;
				end
			end
			if ((state_q == S_DONE) && (!out_valid_q || !out_stall)) begin
				out_valid_q  <= 1'b1;
				over_limit_q <= res_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && !clearing_q) begin
						state_q <= S_H2;
					end
				end
				S_H2:   state_q <= S_H3;
				S_H3:   state_q <= S_H4;
				S_H4:   state_q <= S_H5;
				S_H5:   state_q <= S_MOD1;
				S_MOD1: state_q <= S_MOD2;
				S_MOD2: state_q <= S_READ;
				S_READ: state_q <= S_EVAL;
				S_EVAL: state_q <= S_DEC;
				S_DEC:  state_q <= S_DONE;
				S_DONE: begin
					// hold the result until the output register is free
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall   = (state_q != S_IDLE) || clearing_q;
	assign out_valid  = out_valid_q;
	assign over_limit = over_limit_q;
	assign cfg_ready  = 1'b1;

endmodule

`default_nettype wire
